/* sv/perspective_floor_texture_mapper_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the perspective floor texture mapper
// Concurrent checks that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_FLOOR_TEXTURE_MAPPER_MACROS_SVH
`define PERSPECTIVE_FLOOR_TEXTURE_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
`define PFT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PFT_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PFT_ASSERT(name, clk, rst, prop, msg)
`define PFT_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`endif
`endif

/* sv/pft_pkg.sv */
// ---------------------------------------------------------------------------
// pft_pkg
// Shared types and constants of the perspective floor texture mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package pft_pkg;

  localparam int TEX_SIDE        = 64;
  localparam int TEX_BITS        = $clog2(TEX_SIDE);
  localparam int TEX_AW          = 2 * TEX_BITS;
  localparam int SHADE_ENTRIES   = 256;
  localparam int SHADE_AW        = $clog2(SHADE_ENTRIES);
  localparam int SCREEN_WIDTH    = 320;
  localparam int VIEW_HEIGHT     = 200;
  localparam int FLOOR_SCALE     = 24;
  localparam int TEX_SHIFT       = 18;
  localparam int NUM_SCALE       = 32'h7fff;

  localparam int ROW_STEP_BITS   = 4;
  localparam int ROW_DIV_STAGES  = 32 / ROW_STEP_BITS;
  localparam int STEP_STEP_BITS  = 2;
  localparam int STEP_DIV_STAGES = 32 / STEP_STEP_BITS;

  localparam int REG_IDX_W       = 3;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_TEXEL = 2'd1,
    OP_SHADE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_EYE_X        = 3'd0,
    REG_EYE_Y        = 3'd1,
    REG_SINE         = 3'd2,
    REG_COSINE       = 3'd3,
    REG_STEP_DIVISOR = 3'd4,
    REG_VSHIFT       = 3'd5,
    REG_HORIZON      = 3'd6,
    REG_ACTIVE_WIDTH = 3'd7
  } reg_t;

  localparam logic [17:0] COSINE_RESET  = 18'h10000;
  localparam logic [30:0] DIVISOR_RESET = 31'd65536;
  localparam logic [7:0]  HORIZON_RESET = 8'd100;
  localparam logic [8:0]  WIDTH_RESET   = 9'd320;

  typedef struct packed {
    logic [31:0] eye_x;
    logic [31:0] eye_y;
    logic [17:0] sine_of_angle;
    logic [17:0] cosine_of_angle;
    logic [30:0] step_divisor;
    logic [8:0]  vertical_shift;
    logic [7:0]  horizon_row;
    logic [8:0]  active_width;
  } cfg_t;

  // per-word payload that rides alongside the arithmetic
  typedef struct packed {
    op_t               op;
    logic              drawable;
    logic [7:0]        row;
    logic [8:0]        col;
    logic [TEX_AW-1:0] index;
    logic [7:0]        value;
  } item_t;

endpackage

`default_nettype wire

/* sv/perspective_floor_texture_mapper.sv */
// ---------------------------------------------------------------------------
// perspective_floor_texture_mapper
// Maps one floor or ceiling pixel per input word to a shaded color. Texel
// and shade loads travel the same pipe and fill the 64x64 texture and the
// 256-entry shade table in stream order, each giving one undrawn result word.
// The pipe takes one word every clock while the output is not stalled and
// returns one result word per input word, through the two pipelined
// dividers (8 stages for distance over row, 18 for distance over the step
// divisor), plus 3 front and 7 texture stages. The user must write
// configuration only while no word is in flight; the block does not check.
// ---------------------------------------------------------------------------
`default_nettype none
`include "perspective_floor_texture_mapper_macros.svh"

module perspective_floor_texture_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [pft_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // surface_height, distance_row, column, clip_row, table_index, table_value
  input  logic [79:0] s_tdata,
  // op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // screen_row, screen_column, color
  output logic [31:0] m_tdata,
  // draw
  output logic [0:0]  m_tuser
);

  pft_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{eye_x: 32'd0, eye_y: 32'd0, sine_of_angle: 18'd0,
               cosine_of_angle: pft_pkg::COSINE_RESET,
               step_divisor: pft_pkg::DIVISOR_RESET, vertical_shift: 9'd0,
               horizon_row: pft_pkg::HORIZON_RESET,
               active_width: pft_pkg::WIDTH_RESET};
    end else if (cfg_we) begin
      case (pft_pkg::reg_t'(cfg_index))
        pft_pkg::REG_EYE_X:        cfg.eye_x           <= cfg_data;
        pft_pkg::REG_EYE_Y:        cfg.eye_y           <= cfg_data;
        pft_pkg::REG_SINE:         cfg.sine_of_angle   <= cfg_data[17:0];
        pft_pkg::REG_COSINE:       cfg.cosine_of_angle <= cfg_data[17:0];
        pft_pkg::REG_STEP_DIVISOR: cfg.step_divisor    <= cfg_data[30:0];
        pft_pkg::REG_VSHIFT:       cfg.vertical_shift  <= cfg_data[8:0];
        pft_pkg::REG_HORIZON:      cfg.horizon_row     <= cfg_data[7:0];
        pft_pkg::REG_ACTIVE_WIDTH: cfg.active_width    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic           f_valid, f_ready;
  pft_pkg::item_t f_item;
  logic [31:0]    f_num;
  logic [8:0]     f_den;

  pft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (pft_pkg::op_t'(s_tuser)),
    .in_height(s_tdata[31:0]),
    .in_row   (s_tdata[39:32]),
    .in_col   (s_tdata[48:40]),
    .in_clip  (s_tdata[56:49]),
    .in_index (s_tdata[68:57]),
    .in_value (s_tdata[76:69]),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_item (f_item),
    .out_num  (f_num),
    .out_den  (f_den)
  );

  logic           r_valid, r_ready;
  pft_pkg::item_t r_item;
  logic [31:0]    r_dist;

  pft_row_div u_row_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_item  (f_item),
    .in_num   (f_num),
    .in_den   (f_den),
    .out_valid(r_valid),
    .out_ready(r_ready),
    .out_item (r_item),
    .out_dist (r_dist)
  );

  logic           d_valid, d_ready;
  pft_pkg::item_t d_item;
  logic [31:0]    d_dist, d_step;

  pft_step_div u_step_div (
    .clk        (clk),
    .rst        (rst),
    .cfg_divisor(cfg.step_divisor),
    .in_valid   (r_valid),
    .in_ready   (r_ready),
    .in_item    (r_item),
    .in_dist    (r_dist),
    .out_valid  (d_valid),
    .out_ready  (d_ready),
    .out_item   (d_item),
    .out_dist   (d_dist),
    .out_step   (d_step)
  );

  logic [7:0] o_row, o_color;
  logic [8:0] o_col;

  pft_texel u_texel (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .in_item  (d_item),
    .in_dist  (d_dist),
    .in_step  (d_step),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_draw (m_tuser[0]),
    .out_row  (o_row),
    .out_col  (o_col),
    .out_color(o_color)
  );

  assign m_tdata = {7'd0, o_color, o_col, o_row};

  `PFT_ASSERT_IMPLY(a_undrawn_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata == 32'd0, "undrawn word carries data")
  `PFT_ASSERT_IMPLY(a_col_in_width, clk, rst, m_tvalid && m_tuser[0], m_tdata[16:8] < cfg.active_width, "drawn column past active width")
  `PFT_ASSERT_IMPLY(a_stall_full, clk, rst, !s_tready, m_tvalid, "input stalled with output empty")

endmodule

`default_nettype wire

/* sv/pft_ram.sv */
// ---------------------------------------------------------------------------
// pft_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/pft_front.sv */
// ---------------------------------------------------------------------------
// pft_front
// Three-stage front end: plane side, numerator, first drawn row and cull.
// ---------------------------------------------------------------------------
`default_nettype none

module pft_front (
  input  logic               clk,
  input  logic               rst,
  input  pft_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  pft_pkg::op_t       in_op,
  input  logic [31:0]        in_height,
  input  logic [7:0]         in_row,
  input  logic [8:0]         in_col,
  input  logic [7:0]         in_clip,
  input  logic [pft_pkg::TEX_AW-1:0] in_index,
  input  logic [7:0]         in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output pft_pkg::item_t     out_item,
  output logic [31:0]        out_num,
  output logic [8:0]         out_den
);

  localparam int M = 3;

  typedef struct packed {
    pft_pkg::op_t              op;
    logic [7:0]                y;
    logic [8:0]                col;
    logic [7:0]                clip;
    logic [pft_pkg::TEX_AW-1:0] index;
    logic [7:0]                value;
  } raw_t;

  logic [M:1] vld;
  logic [M:1] en;

  for (genvar k = 1; k <= M; k++) begin : g_vld
    logic src;
    if (k == 1) begin : g_head
      assign src = in_valid;
    end else begin : g_body
      assign src = vld[k-1];
    end
    if (k == M) begin : g_tail
      assign en[k] = ~vld[k] | out_ready;
    end else begin : g_mid
      assign en[k] = ~vld[k] | en[k+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= src;
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[M];

  // stage 1: magnitude of the height and 0x7fff * height
  raw_t        s1_raw;
  logic [31:0] s1_phmag;
  logic [31:0] s1_num;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_raw   <= '{op: in_op, y: in_row, col: in_col, clip: in_clip,
                    index: in_index, value: in_value};
      s1_phmag <= in_height[31] ? 32'd0 - in_height : in_height;
      s1_num   <= 32'(in_height * 32'(pft_pkg::NUM_SCALE));
    end
  end

  // stage 2: side, numerator magnitude, checks that do not need the first row
  logic [28:0] scaled;
  logic        floor2;
  logic        row_ok;
  logic        ok2;
  logic [7:0]  hh;

  assign hh     = cfg.horizon_row;
  assign scaled = 29'(s1_phmag[31:8]) * 29'(pft_pkg::FLOOR_SCALE);
  assign floor2 = s1_num[31];

  always_comb begin
    if (floor2) begin
      row_ok = (9'(s1_raw.y) + 9'(hh)) < 9'(pft_pkg::VIEW_HEIGHT);
    end else begin
      row_ok = (s1_raw.y < hh) &&
               !((10'(s1_raw.y) + 10'(pft_pkg::VIEW_HEIGHT)) < 10'(hh));
    end
    ok2 = (s1_raw.op == pft_pkg::OP_DRAW) && row_ok &&
          (s1_raw.col < cfg.active_width) &&
          (10'(s1_raw.col) < 10'(pft_pkg::SCREEN_WIDTH)) &&
          (s1_raw.clip <= s1_raw.y);
  end

  raw_t        s2_raw;
  logic [12:0] s2_y0base;
  logic [31:0] s2_num;
  logic        s2_ok;
  logic [7:0]  s2_screen_row;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_raw        <= s1_raw;
      s2_y0base     <= scaled[28:16];
      s2_num        <= floor2 ? 32'd0 - s1_num : s1_num;
      s2_ok         <= ok2;
      s2_screen_row <= floor2 ? 8'(hh + s1_raw.y) : 8'(hh - s1_raw.y - 8'd1);
    end
  end

  // stage 3: first drawn row against the horizon and the row itself
  logic [8:0]         shift_mag;
  logic signed [13:0] y0;
  logic signed [13:0] y0c;
  logic               past_horizon;
  logic               above_first;

  always_comb begin
    shift_mag    = cfg.vertical_shift[8] ? 9'd0 - cfg.vertical_shift : cfg.vertical_shift;
    y0           = $signed({1'b0, s2_y0base}) - $signed({5'b0, shift_mag});
    past_horizon = y0 > $signed({6'b0, hh});
    y0c          = (y0 <= 14'sd0) ? 14'sd1 : y0;
    above_first  = $signed({6'b0, s2_raw.y}) < y0c;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_item <= '{op: s2_raw.op,
                    drawable: s2_ok && !past_horizon && !above_first,
                    row: s2_screen_row, col: s2_raw.col,
                    index: s2_raw.index, value: s2_raw.value};
      out_num  <= s2_num;
      out_den  <= 9'(s2_raw.y) + 9'd1;
    end
  end

endmodule

`default_nettype wire

/* sv/pft_row_div.sv */
// ---------------------------------------------------------------------------
// pft_row_div
// Pipelined restoring divider: numerator over row plus one, 4 bits a stage.
// ---------------------------------------------------------------------------
`default_nettype none

module pft_row_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pft_pkg::item_t in_item,
  input  logic [31:0]    in_num,
  input  logic [8:0]     in_den,
  output logic           out_valid,
  input  logic           out_ready,
  output pft_pkg::item_t out_item,
  output logic [31:0]    out_dist
);

  localparam int N = pft_pkg::ROW_DIV_STAGES;

  typedef struct packed {
    logic [8:0]  r;
    logic [31:0] n;
    logic [31:0] q;
  } rdiv_t;

  function automatic rdiv_t row_steps(rdiv_t s, logic [8:0] d);
    rdiv_t      o;
    logic [9:0] t;
    o = s;
    for (int i = 0; i < pft_pkg::ROW_STEP_BITS; i++) begin
      t   = {o.r, o.n[31]};
      o.n = {o.n[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        o.r = 9'(t - {1'b0, d});
        o.q = {o.q[30:0], 1'b1};
      end else begin
        o.r = t[8:0];
        o.q = {o.q[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [N:1]     vld;
  logic [N:1]     en;
  rdiv_t          st  [1:N];
  logic [8:0]     den [1:N];
  pft_pkg::item_t itm [1:N];

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic           v_src;
    rdiv_t          s_src;
    logic [8:0]     d_src;
    pft_pkg::item_t i_src;
    if (k == 1) begin : g_head
      assign v_src = in_valid;
      assign s_src = '{r: 9'd0, n: in_num, q: 32'd0};
      assign d_src = in_den;
      assign i_src = in_item;
    end else begin : g_body
      assign v_src = vld[k-1];
      assign s_src = st[k-1];
      assign d_src = den[k-1];
      assign i_src = itm[k-1];
    end
    if (k == N) begin : g_tail
      assign en[k] = ~vld[k] | out_ready;
    end else begin : g_mid
      assign en[k] = ~vld[k] | en[k+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= v_src;
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k]  <= row_steps(s_src, d_src);
        den[k] <= d_src;
        itm[k] <= i_src;
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[N];
  assign out_item  = itm[N];
  // distance is the quotient times 256, wrapped to 32 bits
  assign out_dist  = {st[N].q[23:0], 8'd0};

endmodule

`default_nettype wire

/* sv/pft_step_div.sv */
// ---------------------------------------------------------------------------
// pft_step_div
// Pipelined signed divide of distance by the step divisor, 2 bits a stage.
// ---------------------------------------------------------------------------
`default_nettype none

module pft_step_div (
  input  logic           clk,
  input  logic           rst,
  input  logic [30:0]    cfg_divisor,
  input  logic           in_valid,
  output logic           in_ready,
  input  pft_pkg::item_t in_item,
  input  logic [31:0]    in_dist,
  output logic           out_valid,
  input  logic           out_ready,
  output pft_pkg::item_t out_item,
  output logic [31:0]    out_dist,
  output logic [31:0]    out_step
);

  localparam int N = pft_pkg::STEP_DIV_STAGES;
  localparam int M = N + 2;

  typedef struct packed {
    logic [30:0] r;
    logic [31:0] n;
    logic [31:0] q;
  } sdiv_t;

  function automatic sdiv_t div_steps(sdiv_t s, logic [30:0] d);
    sdiv_t       o;
    logic [31:0] t;
    o = s;
    for (int i = 0; i < pft_pkg::STEP_STEP_BITS; i++) begin
      t   = {o.r, o.n[31]};
      o.n = {o.n[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        o.r = 31'(t - {1'b0, d});
        o.q = {o.q[30:0], 1'b1};
      end else begin
        o.r = t[30:0];
        o.q = {o.q[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [M:1]  vld;
  logic [M:1]  en;
  logic [30:0] divisor;

  // zero divides as one
  assign divisor = (cfg_divisor == 31'd0) ? 31'd1 : cfg_divisor;

  for (genvar k = 1; k <= M; k++) begin : g_vld
    logic src;
    if (k == 1) begin : g_head
      assign src = in_valid;
    end else begin : g_body
      assign src = vld[k-1];
    end
    if (k == M) begin : g_tail
      assign en[k] = ~vld[k] | out_ready;
    end else begin : g_mid
      assign en[k] = ~vld[k] | en[k+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= src;
      end
    end
  end

  // magnitude of the dividend
  pft_pkg::item_t p_item;
  logic [31:0]    p_dist;
  logic [31:0]    p_mag;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_item <= in_item;
      p_dist <= in_dist;
      p_mag  <= in_dist[31] ? 32'd0 - in_dist : in_dist;
    end
  end

  sdiv_t          st        [1:N];
  pft_pkg::item_t itm       [1:N];
  logic [31:0]    dist_pipe [1:N];

  for (genvar j = 1; j <= N; j++) begin : g_div
    sdiv_t          s_src;
    pft_pkg::item_t i_src;
    logic [31:0]    d_src;
    if (j == 1) begin : g_head
      assign s_src = '{r: 31'd0, n: p_mag, q: 32'd0};
      assign i_src = p_item;
      assign d_src = p_dist;
    end else begin : g_body
      assign s_src = st[j-1];
      assign i_src = itm[j-1];
      assign d_src = dist_pipe[j-1];
    end
    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        st[j]        <= div_steps(s_src, divisor);
        itm[j]       <= i_src;
        dist_pipe[j] <= d_src;
      end
    end
  end

  // quotient truncates toward zero, so the sign is applied to the magnitude
  always_ff @(posedge clk) begin
    if (en[M]) begin
      out_item <= itm[N];
      out_dist <= dist_pipe[N];
      out_step <= dist_pipe[N][31] ? 32'd0 - st[N].q : st[N].q;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[M];

endmodule

`default_nettype wire

/* sv/pft_texel.sv */
// ---------------------------------------------------------------------------
// pft_texel
// Texture coordinates across the row, texel and shade lookups, result word.
// ---------------------------------------------------------------------------
`default_nettype none

module pft_texel (
  input  logic           clk,
  input  logic           rst,
  input  pft_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  pft_pkg::item_t in_item,
  input  logic [31:0]    in_dist,
  input  logic [31:0]    in_step,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_draw,
  output logic [7:0]     out_row,
  output logic [8:0]     out_col,
  output logic [7:0]     out_color
);

  localparam int M = 7;

  logic [M:1] vld;
  logic [M:1] en;

  for (genvar k = 1; k <= M; k++) begin : g_vld
    logic src;
    if (k == 1) begin : g_head
      assign src = in_valid;
    end else begin : g_body
      assign src = vld[k-1];
    end
    if (k == M) begin : g_tail
      assign en[k] = ~vld[k] | out_ready;
    end else begin : g_mid
      assign en[k] = ~vld[k] | en[k+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= src;
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[M];

  // stage 1: the four rotation products
  pft_pkg::item_t     it1;
  logic signed [49:0] s1_pu, s1_pv, s1_pdu, s1_pdv;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      it1    <= in_item;
      s1_pu  <= $signed(in_dist) * $signed(cfg.cosine_of_angle);
      s1_pv  <= $signed(in_dist) * $signed(cfg.sine_of_angle);
      s1_pdu <= $signed(in_step) * $signed(cfg.sine_of_angle);
      s1_pdv <= $signed(in_step) * $signed(cfg.cosine_of_angle);
    end
  end

  // stage 2: row start, per-column step, column offset from center
  pft_pkg::item_t     it2;
  logic [31:0]        s2_gu, s2_gv, s2_du, s2_dv;
  logic signed [9:0]  s2_xm;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      it2   <= it1;
      s2_gu <= {8'd0, cfg.eye_x[15:0], 8'd0} + 32'(s1_pu[47:16]);
      s2_gv <= 32'(s1_pv[47:16]) - {8'd0, cfg.eye_y[15:0], 8'd0};
      s2_du <= 32'(s1_pdu[47:16]);
      s2_dv <= 32'd0 - 32'(s1_pdv[47:16]);
      s2_xm <= $signed({1'b0, it1.col}) - $signed({2'b0, cfg.active_width[8:1]});
    end
  end

  // stage 3: offset times step, wrapped
  pft_pkg::item_t it3;
  logic [31:0]    s3_gu, s3_gv, s3_mu, s3_mv;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      it3   <= it2;
      s3_gu <= s2_gu;
      s3_gv <= s2_gv;
      s3_mu <= 32'(s2_xm * $signed(s2_du));
      s3_mv <= 32'(s2_xm * $signed(s2_dv));
    end
  end

  // stage 4: final coordinates to texel address
  pft_pkg::item_t             it4;
  logic [pft_pkg::TEX_AW-1:0] s4_addr;
  logic [31:0]                gu, gv_neg;

  assign gu     = s3_gu + s3_mu;
  assign gv_neg = 32'd0 - (s3_gv + s3_mv);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      it4     <= it3;
      s4_addr <= {gu[pft_pkg::TEX_SHIFT +: pft_pkg::TEX_BITS],
                  gv_neg[pft_pkg::TEX_SHIFT +: pft_pkg::TEX_BITS]};
    end
  end

  // stage 5: texture read, or texel load
  pft_pkg::item_t it5;
  logic [7:0]     texel;

  pft_ram #(.WIDTH(8), .DEPTH(pft_pkg::TEX_SIDE * pft_pkg::TEX_SIDE)) u_texture (
    .clk  (clk),
    .we   (en[5] & vld[4] & (it4.op == pft_pkg::OP_TEXEL)),
    .waddr(it4.index),
    .wdata(it4.value),
    .re   (en[5]),
    .raddr(s4_addr),
    .rdata(texel)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      it5 <= it4;
    end
  end

  // stage 6: shade read, or shade load
  pft_pkg::item_t it6;
  logic [7:0]     shade;

  pft_ram #(.WIDTH(8), .DEPTH(pft_pkg::SHADE_ENTRIES)) u_shade (
    .clk  (clk),
    .we   (en[6] & vld[5] & (it5.op == pft_pkg::OP_SHADE)),
    .waddr(it5.index[pft_pkg::SHADE_AW-1:0]),
    .wdata(it5.value),
    .re   (en[6]),
    .raddr(texel),
    .rdata(shade)
  );

  always_ff @(posedge clk) begin
    if (en[6]) begin
      it6 <= it5;
    end
  end

  // stage 7: result word, all zero when nothing is drawn
  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_draw  <= it6.drawable;
      out_row   <= it6.drawable ? it6.row : 8'd0;
      out_col   <= it6.drawable ? it6.col : 9'd0;
      out_color <= it6.drawable ? shade : 8'd0;
    end
  end

endmodule

`default_nettype wire
